// File: sv/tilt_guarded_heading_odometry_assert.svh
// Assertion macros shared by the checker of the odometry block.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef TILT_GUARDED_HEADING_ODOMETRY_ASSERT_SVH
`define TILT_GUARDED_HEADING_ODOMETRY_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define THG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define THG_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// File: sv/thg_pkg.sv
// Shared types, codes and constants of the tilt guarded heading odometry block.
// Depends on nothing.
package thg_pkg;

	localparam logic [1:0] REQ_IMU   = 2'd0;
	localparam logic [1:0] REQ_VEL   = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam logic [2:0] CFG_TILT_LIMIT  = 3'd0;
	localparam logic [2:0] CFG_TILT_RUN    = 3'd1;
	localparam logic [2:0] CFG_RESTABLE    = 3'd2;
	localparam logic [2:0] CFG_SCALE_X     = 3'd3;
	localparam logic [2:0] CFG_SCALE_Y     = 3'd4;
	localparam logic [2:0] CFG_WALK_LIMIT  = 3'd5;

	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic [32:0]        TWO_PI_U33  = 33'd6746518852;
	localparam logic signed [31:0] INV_GAIN    = 32'sd652032874;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] body_speed_x;
		logic signed [15:0] body_speed_y;
		logic [19:0]        elapsed_us;
	} req_t;

	typedef struct packed {
		logic               is_stable;
		logic               leans_forward;
		logic               is_walking;
		logic               heading_valid;
		logic signed [31:0] heading_rel;
		logic signed [47:0] odom_x;
		logic signed [47:0] odom_y;
	} res_t;

	typedef struct packed {
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} cs_t;

	// Arctangent of 2^-i in Q30, truncated.
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

// File: sv/thg_intf.sv
// Valid/ready channel interfaces of the odometry block: request, result, register write.
// Depends on thg_pkg.
interface thg_req_if;
	logic          valid;
	logic          ready;
	thg_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface thg_res_if;
	logic          valid;
	logic          ready;
	thg_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface thg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// File: sv/tilt_guarded_heading_odometry.sv
// Top level of the tilt guarded heading odometry block: sequencer, state and shared multiplier.
// Depends on thg_pkg, thg_intf and thg_cordic.
//
//   Channel  Modport  Moves
//   req      sink     one request item: IMU sample, velocity command or time tick
//   res      source   one status item for every request item
//   cfg      sink     one register write (index, data), always ready
//
// An IMU sample, a velocity command, a zero tick or a tick that does not integrate
// passes through the states EXEC, SCX, SCY and FIN; its result is loaded into the
// output register in FIN once that register is free. An integrating tick also waits
// in WAIT for the CORDIC (angle reduction, a fold step, CORDIC_STEPS rotations, at
// most 24) and then runs the shared multiplier states MUL1 to MUL7 before SCX.
// The request side is ready only while the sequencer idles.
// A finished result waits in the output register while the next item is accepted.
// Reset is asynchronous and active low; it loads the register defaults and clears state.
module tilt_guarded_heading_odometry #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int POS_WIDTH = 48,
	parameter int CORDIC_STEPS = 16
) (
	input logic        clk,
	input logic        arst_n,
	thg_req_if.sink    req,
	thg_res_if.source  res,
	thg_cfg_if.sink    cfg
);
	localparam int AW = 63 - ANGLE_FRAC_BITS;
	localparam int ASH = 30 - ANGLE_FRAC_BITS;
	// Pi in the input angle format, rounded to nearest.
	localparam longint PI_Q = (64'sd3373259426 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> ASH;
	localparam logic signed [21:0] PI22 = 22'(PI_Q);
	localparam logic signed [21:0] TWO_PI22 = 22'(2 * PI_Q);
	localparam int SW = ((POS_WIDTH > 55) ? POS_WIDTH : 55) + 1;
	localparam logic signed [SW-1:0] PHI = {{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] PLO = ~PHI;
	localparam int SPW = POS_WIDTH + 9;
	localparam int PW = (SPW > 49) ? SPW : 49;
	localparam logic signed [PW-1:0] OMAX = {{(PW - 47){1'b0}}, {47{1'b1}}};
	localparam logic signed [PW-1:0] OMIN = ~OMAX;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_EXEC = 14'b00000000000010,
		ST_WAIT = 14'b00000000000100,
		ST_MUL1 = 14'b00000000001000,
		ST_MUL2 = 14'b00000000010000,
		ST_MUL3 = 14'b00000000100000,
		ST_MUL4 = 14'b00000001000000,
		ST_MUL5 = 14'b00000010000000,
		ST_MUL6 = 14'b00000100000000,
		ST_MUL7 = 14'b00001000000000,
		ST_SCX  = 14'b00010000000000,
		ST_SCY  = 14'b00100000000000,
		ST_FIN  = 14'b01000000000000,
		ST_HOLD = 14'b10000000000000
	} state_t;

	state_t state_q;
	thg_pkg::req_t req_q;

	// Registers.
	logic [14:0] tilt_limit_q;
	logic [7:0]  run_need_q;
	logic [25:0] wait_q;
	logic [7:0]  kx_q, ky_q;
	logic [14:0] walk_q;

	// Block state.
	logic                       hready_q, stable_q, fwd_q;
	logic signed [15:0]         first_q, prev_q;
	logic signed [31:0]         uw_q;
	logic signed [POS_WIDTH-1:0] posx_q, posy_q;
	logic signed [15:0]         spx_q, spy_q, ppx_q, ppy_q;
	logic [7:0]                 run_q;
	logic [31:0]                since_q;

	// Datapath registers.
	logic signed [53:0]     prod_q, acc_q;
	logic signed [31:0]     rx_q, ry_q;
	logic signed [SPW-1:0]  sprod_q;
	logic signed [47:0]     ox_q;
	logic                   res_valid_q;
	thg_pkg::res_t          res_q;

	// Heading relative to the first yaw, saturated to 32 bits.
	logic signed [32:0] hd33;
	logic signed [31:0] hd_sat;
	assign hd33 = 33'(uw_q) - 33'(first_q);
	assign hd_sat = (hd33 > 33'sd2147483647) ? 32'sh7FFFFFFF :
		(hd33 < -33'sd2147483648) ? 32'sh80000000 : 32'(hd33);

	// Rotation angle in Q30: heading plus a quarter turn.
	logic signed [AW:0] ang;
	assign ang = ((AW + 1)'(hd_sat) <<< ASH) + (AW + 1)'(thg_pkg::HALF_PI_Q30);

	logic         cs_start, cs_done;
	thg_pkg::cs_t cs;

	thg_cordic #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cs_start),
		.angle(ang),
		.done(cs_done),
		.result(cs)
	);

	// IMU sample arithmetic.
	logic signed [16:0] r17, p17, lim17, ra, pa;
	logic               tilted;
	logic [7:0]         run_inc;
	logic signed [21:0] dyaw;
	logic signed [32:0] uw_sum;
	logic signed [31:0] uw_new;

	always_comb begin
		r17 = 17'(req_q.roll_angle);
		p17 = 17'(req_q.pitch_angle);
		lim17 = signed'({2'b00, tilt_limit_q});
		ra = (r17 < 0) ? -r17 : r17;
		pa = (p17 < 0) ? -p17 : p17;
		tilted = (ra > lim17) || (pa > lim17);
		run_inc = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
		dyaw = 22'(req_q.yaw_angle) - 22'(prev_q);
		if (dyaw > PI22) dyaw = dyaw - TWO_PI22;
		if (dyaw < -PI22) dyaw = dyaw + TWO_PI22;
		uw_sum = 33'(uw_q) + 33'(dyaw);
		uw_new = (uw_sum > 33'sd2147483647) ? 32'sh7FFFFFFF :
			(uw_sum < -33'sd2147483648) ? 32'sh80000000 : 32'(uw_sum);
	end

	logic [32:0] since_sum;
	assign since_sum = 33'(since_q) + 33'(req_q.elapsed_us);

	// Shared multiplier for the rotation and the time scaling.
	logic signed [16:0] vsx, vsy;
	logic signed [21:0] dt22;
	logic signed [31:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [53:0] prod_d;

	assign vsx = 17'(ppx_q) + 17'(spx_q);
	assign vsy = 17'(ppy_q) + 17'(spy_q);
	assign dt22 = signed'({2'b00, req_q.elapsed_us});

	always_comb begin
		case (state_q)
			ST_MUL1: begin mul_a = cs.cos_v; mul_b = 22'(vsx); end
			ST_MUL2: begin mul_a = cs.sin_v; mul_b = 22'(vsy); end
			ST_MUL3: begin mul_a = cs.sin_v; mul_b = 22'(vsx); end
			ST_MUL4: begin mul_a = cs.cos_v; mul_b = 22'(vsy); end
			ST_MUL5: begin mul_a = rx_q; mul_b = dt22; end
			ST_MUL6: begin mul_a = ry_q; mul_b = dt22; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod_d = mul_a * mul_b;

	logic signed [54:0] diff55, sum55, inc55;
	assign diff55 = 55'(acc_q) - 55'(prod_q);
	assign sum55 = 55'(acc_q) + 55'(prod_q);
	assign inc55 = (55'(prod_q) + 55'sd512) >>> 10;

	// Saturating position update, x in MUL6 and y in MUL7.
	logic signed [POS_WIDTH-1:0] pos_sel, pos_new;
	logic signed [SW-1:0]        pos_sum;
	assign pos_sel = (state_q == ST_MUL6) ? posx_q : posy_q;
	assign pos_sum = SW'(pos_sel) + SW'(inc55);
	assign pos_new = (pos_sum > PHI) ? POS_WIDTH'(PHI) :
		(pos_sum < PLO) ? POS_WIDTH'(PLO) : POS_WIDTH'(pos_sum);

	// Report scaling.
	logic signed [POS_WIDTH-1:0] sc_pos;
	logic signed [8:0]           sc_k;
	logic signed [SPW-1:0]       sprod_d;
	logic signed [PW-1:0]        sp_ext;
	logic signed [47:0]          scaled;
	assign sc_pos = (state_q == ST_SCX) ? posx_q : posy_q;
	assign sc_k = signed'({1'b0, (state_q == ST_SCX) ? kx_q : ky_q});
	assign sprod_d = sc_pos * sc_k;
	assign sp_ext = PW'(sprod_q);
	assign scaled = (sp_ext > OMAX) ? 48'(OMAX) : (sp_ext < OMIN) ? 48'(OMIN) : 48'(sp_ext);

	logic signed [16:0] ax, ay, wl17;
	logic               walking;
	assign ax = (spx_q < 0) ? -17'(spx_q) : 17'(spx_q);
	assign ay = (spy_q < 0) ? -17'(spy_q) : 17'(spy_q);
	assign wl17 = signed'({2'b00, walk_q});
	assign walking = (ax > wl17) || (ay > wl17);

	logic integrate, fin_load;
	assign integrate = (req_q.req_type == thg_pkg::REQ_TICK) && (req_q.elapsed_us != '0) &&
		hready_q && stable_q;
	assign cs_start = (state_q == ST_EXEC) && integrate;
	assign fin_load = (state_q == ST_FIN) && (!res_valid_q || res.ready);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data = res_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_limit_q <= 15'd4096;
			run_need_q <= 8'd2;
			wait_q <= 26'd5000000;
			kx_q <= 8'd30;
			ky_q <= 8'd40;
			walk_q <= 15'd410;
		end else if (cfg.valid) begin
			case (cfg.index)
				thg_pkg::CFG_TILT_LIMIT: tilt_limit_q <= cfg.wdata[14:0];
				thg_pkg::CFG_TILT_RUN:   run_need_q <= cfg.wdata[7:0];
				thg_pkg::CFG_RESTABLE:   wait_q <= cfg.wdata[25:0];
				thg_pkg::CFG_SCALE_X:    kx_q <= cfg.wdata[7:0];
				thg_pkg::CFG_SCALE_Y:    ky_q <= cfg.wdata[7:0];
				thg_pkg::CFG_WALK_LIMIT: walk_q <= cfg.wdata[14:0];
				default: ;
			endcase
		end
	end

	// Sequencer and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hready_q <= 1'b0;
			stable_q <= 1'b1;
			fwd_q <= 1'b0;
			first_q <= '0;
			prev_q <= '0;
			uw_q <= '0;
			posx_q <= '0;
			posy_q <= '0;
			spx_q <= '0;
			spy_q <= '0;
			ppx_q <= '0;
			ppy_q <= '0;
			run_q <= '0;
			since_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fin_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_SCX;
					case (req_q.req_type)
						thg_pkg::REQ_IMU: begin
							if (!hready_q) begin
								first_q <= req_q.yaw_angle;
								uw_q <= 32'(req_q.yaw_angle);
								hready_q <= 1'b1;
							end else begin
								uw_q <= uw_new;
							end
							prev_q <= req_q.yaw_angle;
							if (tilted) begin
								run_q <= run_inc;
								if (run_inc >= run_need_q) begin
									stable_q <= 1'b0;
									since_q <= '0;
									if (p17 > lim17) fwd_q <= 1'b1;
									else if (p17 < -lim17) fwd_q <= 1'b0;
								end
							end else begin
								run_q <= '0;
								if (!stable_q && (since_q > 32'(wait_q))) stable_q <= 1'b1;
							end
						end
						thg_pkg::REQ_VEL: begin
							spx_q <= req_q.body_speed_x;
							spy_q <= req_q.body_speed_y;
						end
						thg_pkg::REQ_TICK: begin
							if (req_q.elapsed_us != '0) begin
								since_q <= since_sum[32] ? 32'hFFFFFFFF : since_sum[31:0];
								if (integrate) state_q <= ST_WAIT;
							end
						end
						default: ;
					endcase
				end
				ST_WAIT: begin
					if (cs_done) state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_MUL4;
				ST_MUL4: state_q <= ST_MUL5;
				ST_MUL5: state_q <= ST_MUL6;
				ST_MUL6: begin
					posx_q <= pos_new;
					state_q <= ST_MUL7;
				end
				ST_MUL7: begin
					posy_q <= pos_new;
					ppx_q <= spx_q;
					ppy_q <= spy_q;
					state_q <= ST_SCX;
				end
				ST_SCX: state_q <= ST_SCY;
				ST_SCY: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_load) state_q <= ST_IDLE;
				end
				ST_HOLD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) req_q <= req.data;
		prod_q <= prod_d;
		case (state_q)
			ST_MUL2: acc_q <= prod_q;
			ST_MUL3: rx_q <= 32'(diff55 >>> 21);
			ST_MUL4: acc_q <= prod_q;
			ST_MUL5: ry_q <= 32'(sum55 >>> 21);
			default: ;
		endcase
		if (state_q == ST_SCX || state_q == ST_SCY) sprod_q <= sprod_d;
		if (state_q == ST_SCY) ox_q <= scaled;
		if (fin_load) begin
			res_q.is_stable <= stable_q;
			res_q.leans_forward <= fwd_q;
			res_q.is_walking <= walking;
			res_q.heading_valid <= hready_q;
			res_q.heading_rel <= hd_sat;
			res_q.odom_x <= ox_q;
			res_q.odom_y <= scaled;
		end
	end
endmodule

// File: sv/thg_cordic.sv
// Iterative angle reduction and rotation-mode CORDIC for cosine and sine in Q30.
// Depends on thg_pkg.
module thg_cordic #(
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [63-ANGLE_FRAC_BITS:0] angle,
	output logic                           done,
	output thg_pkg::cs_t                   result
);
	localparam int AW = 63 - ANGLE_FRAC_BITS;
	localparam int NRED = AW - 32;
	localparam int KW = $clog2(NRED);
	localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int IW = $clog2(NSTEPS);
	localparam logic [AW-1:0] TWO_PI_AW = AW'(thg_pkg::TWO_PI_U33);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_RED  = 4'b0010,
		C_FOLD = 4'b0100,
		C_ROT  = 4'b1000
	} cstate_t;

	cstate_t            state_q;
	logic [AW-1:0]      r_q;
	logic               sign_q;
	logic [KW-1:0]      k_q;
	logic [IW-1:0]      i_q;
	logic signed [34:0] z_q;
	logic signed [31:0] x_q, y_q;
	logic               neg_q;
	logic               done_q;
	thg_pkg::cs_t       result_q;

	logic [AW-1:0]      sub_w;
	logic signed [34:0] zr, zw, zf;
	logic               negf;
	logic signed [31:0] xn, yn;
	logic signed [34:0] zn, at35;

	assign sub_w = TWO_PI_AW << k_q;
	assign at35 = signed'(35'(thg_pkg::atan_q30(5'(i_q))));

	always_comb begin
		zr = signed'({2'b00, r_q[32:0]});
		zw = sign_q ? -zr : zr;
		if (zw > thg_pkg::PI_Q30) zw = zw - thg_pkg::TWO_PI_Q30;
		if (zw < -thg_pkg::PI_Q30) zw = zw + thg_pkg::TWO_PI_Q30;
		negf = 1'b0;
		zf = zw;
		if (zw > thg_pkg::HALF_PI_Q30) begin
			zf = zw - thg_pkg::PI_Q30;
			negf = 1'b1;
		end else if (zw < -thg_pkg::HALF_PI_Q30) begin
			zf = zw + thg_pkg::PI_Q30;
			negf = 1'b1;
		end
	end

	always_comb begin
		if (z_q >= 0) begin
			xn = x_q - (y_q >>> i_q);
			yn = y_q + (x_q >>> i_q);
			zn = z_q - at35;
		end else begin
			xn = x_q + (y_q >>> i_q);
			yn = y_q - (x_q >>> i_q);
			zn = z_q + at35;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) state_q <= C_RED;
				end
				C_RED: begin
					if (k_q == '0) state_q <= C_FOLD;
				end
				C_FOLD: state_q <= C_ROT;
				C_ROT: begin
					if (i_q == IW'(NSTEPS - 1)) begin
						state_q <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				sign_q <= angle[AW];
				r_q <= angle[AW] ? AW'(-angle) : AW'(angle);
				k_q <= KW'(NRED - 1);
			end
			C_RED: begin
				if (r_q >= sub_w) r_q <= r_q - sub_w;
				k_q <= k_q - 1'b1;
			end
			C_FOLD: begin
				z_q <= zf;
				neg_q <= negf;
				x_q <= thg_pkg::INV_GAIN;
				y_q <= '0;
				i_q <= '0;
			end
			C_ROT: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				i_q <= i_q + 1'b1;
				if (i_q == IW'(NSTEPS - 1)) begin
					result_q.cos_v <= neg_q ? -xn : xn;
					result_q.sin_v <= neg_q ? -yn : yn;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = result_q;
endmodule

// File: sv/thg_checker.sv
// Port-level checker of the odometry block and its bind to the top level.
// Depends on thg_pkg and the assertion macro header.
`include "tilt_guarded_heading_odometry_assert.svh"

module thg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          res_valid,
	input logic          res_ready,
	input thg_pkg::res_t res_data
);
	`THG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`THG_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_data), "result changed while stalled")
	`THG_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "request taken while busy")
	`THG_ASSERT_NOW(a_head_zero, res_valid && !res_data.heading_valid, res_data.heading_rel == 32'sd0, "heading set before first yaw")
endmodule

bind tilt_guarded_heading_odometry thg_checker u_thg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_data(res.data)
);
